// File: design/sts_pkg.sv
// Shared types, codes and saturation helpers for the tridiagonal solver.
`timescale 1ns / 1ps
package sts_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W  = 6;

	typedef struct packed {
		logic signed [WORD_W-1:0] diag_value;
		logic signed [WORD_W-1:0] off_value;
		logic signed [WORD_W-1:0] rhs_value;
		logic                     last_row;
	} row_t;

	typedef struct packed {
		logic [IDX_W-1:0]         row_index;
		logic signed [WORD_W-1:0] solution_value;
		logic                     singular;
		logic                     last_result;
	} sol_t;

	localparam logic [1:0] MS_RATIO = 2'd0;
	localparam logic [1:0] MS_SRHS  = 2'd1;
	localparam logic [1:0] MS_BACK  = 2'd2;

	localparam logic [1:0] SS_DEN  = 2'd0;
	localparam logic [1:0] SS_NUM  = 2'd1;
	localparam logic [1:0] SS_BACK = 2'd2;

	localparam logic DS_RATIO = 1'b0;
	localparam logic DS_SRHS  = 1'b1;

	typedef struct packed {
		logic       load_in;
		logic       first_row;
		logic       mul_go;
		logic [1:0] mul_sel;
		logic       scale_go;
		logic       sub_go;
		logic [1:0] sub_sel;
		logic       div_go;
		logic       div_sel;
		logic       take_ratio;
		logic       take_srhs;
		logic       save_off;
		logic       clear_solve;
		logic       restart;
		logic       rd_go;
		logic       out_load;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic div_busy;
		logic out_busy;
	} status_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     clip;
	} satw_t;

	function automatic satw_t sub_sat(logic signed [WORD_W-1:0] a,
		logic signed [WORD_W-1:0] b);
		logic signed [WORD_W:0] d;
		satw_t r;
		d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		r.clip = d[WORD_W] ^ d[WORD_W-1];
		if (!r.clip) begin
			r.value = d[WORD_W-1:0];
		end else if (d[WORD_W]) begin
			r.value = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r.value = {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] mag(logic signed [WORD_W-1:0] a);
		return a[WORD_W-1] ? (~a + 1'b1) : a;
	endfunction

endpackage

// File: design/sts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: design/sts_div.sv
// Iterative signed fixed-point divider, one quotient bit per cycle, saturating.
`timescale 1ns / 1ps
module sts_div import sts_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [WORD_W-1:0] numer,
	input  logic signed [WORD_W-1:0] denom,
	output logic                     busy,
	output logic                     done,
	output logic signed [WORD_W-1:0] quot,
	output logic                     fault
);
	localparam int NW = WORD_W + FRAC_BITS;
	localparam int QW = WORD_W + 1;

	logic [NW-1:0]       an;
	logic [WORD_W-1:0]   ad;
	logic                ovf;
	logic [QW-1:0]       rem_q, q_q, lo_q, trial;
	logic [WORD_W-1:0]   ad_q;
	logic                neg_q, busy_q, fin_q, done_q;
	logic [5:0]          cnt_q;
	logic                qbit;

	assign an  = {mag(numer), {FRAC_BITS{1'b0}}};
	assign ad  = mag(denom);
	assign ovf = ({{(2*WORD_W+1-NW){1'b0}}, an} >= {ad, {QW{1'b0}}});
	assign trial = {rem_q[WORD_W-1:0], lo_q[QW-1]};
	assign qbit  = (trial >= {1'b0, ad_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				if (denom == '0 || ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 6'(QW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= numer[WORD_W-1] ^ denom[WORD_W-1];
			ad_q  <= ad;
			rem_q <= QW'(an >> QW);
			lo_q  <= an[QW-1:0];
			q_q   <= '0;
			if (denom == '0) begin
				quot  <= '0;
				fault <= 1'b1;
			end else if (ovf) begin
				fault <= 1'b1;
				quot  <= (numer[WORD_W-1] ^ denom[WORD_W-1]) ?
					{1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
			end else begin
				fault <= 1'b0;
			end
		end else if (busy_q) begin
			rem_q <= qbit ? (trial - {1'b0, ad_q}) : trial;
			q_q   <= {q_q[QW-2:0], qbit};
			lo_q  <= {lo_q[QW-2:0], 1'b0};
		end else if (fin_q) begin
			if (!neg_q && q_q > {2'b00, {(WORD_W-1){1'b1}}}) begin
				quot  <= {1'b0, {(WORD_W-1){1'b1}}};
				fault <= 1'b1;
			end else if (neg_q && q_q > {2'b01, {(WORD_W-1){1'b0}}}) begin
				quot  <= {1'b1, {(WORD_W-1){1'b0}}};
				fault <= 1'b1;
			end else begin
				quot  <= neg_q ? (~q_q[WORD_W-1:0] + 1'b1) : q_q[WORD_W-1:0];
				fault <= 1'b0;
			end
		end
	end

	assign busy = busy_q | fin_q;
	assign done = done_q;
endmodule

// File: design/sts_datapath.sv
// Datapath: operand registers, multiplier, subtractor, divider and stores.
`timescale 1ns / 1ps
module sts_datapath import sts_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16,
	parameter int AW        = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  row_t          row,
	input  cmd_t          cmd,
	input  logic [AW-1:0] addr,
	output status_t       st,
	output logic          sol_valid,
	input  logic          sol_ready,
	output sol_t          sol
);
	logic signed [WORD_W-1:0] diag_q, off_q, rhs_q, den_q, num_q;
	logic signed [WORD_W-1:0] prev_off_q, prev_ratio_q, prev_srhs_q;
	logic signed [WORD_W-1:0] x_q, xtop_q, m_q;
	logic [2*WORD_W-1:0]      prod_q;
	logic                     mneg_q, sing_q, out_valid_q;
	logic signed [WORD_W-1:0] ma, mb, sa, dn, ratio_rd, srhs_rd;
	logic [2*WORD_W-FRAC_BITS-1:0] sh;
	logic signed [WORD_W-1:0] scaled;
	logic                     scale_clip;
	satw_t                    sub_r;
	logic                     div_done, div_busy, div_fault;
	logic signed [WORD_W-1:0] div_quot;

	always_comb begin
		case (cmd.mul_sel)
			MS_RATIO: begin ma = prev_off_q; mb = prev_ratio_q; end
			MS_SRHS:  begin ma = prev_off_q; mb = prev_srhs_q;  end
			MS_BACK:  begin ma = ratio_rd;   mb = x_q;          end
			default:  begin ma = '0;         mb = '0;           end
		endcase
		case (cmd.sub_sel)
			SS_DEN:  sa = diag_q;
			SS_NUM:  sa = rhs_q;
			SS_BACK: sa = srhs_rd;
			default: sa = '0;
		endcase
		dn = (cmd.div_sel == DS_RATIO) ? off_q : num_q;
	end

	assign sh = prod_q[2*WORD_W-1:FRAC_BITS];

	always_comb begin
		if (!mneg_q && sh > {{(WORD_W-FRAC_BITS+1){1'b0}}, {(WORD_W-1){1'b1}}}) begin
			scaled     = {1'b0, {(WORD_W-1){1'b1}}};
			scale_clip = 1'b1;
		end else if (mneg_q &&
			sh > {{(WORD_W-FRAC_BITS){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}}) begin
			scaled     = {1'b1, {(WORD_W-1){1'b0}}};
			scale_clip = 1'b1;
		end else begin
			scaled     = mneg_q ? (~sh[WORD_W-1:0] + 1'b1) : sh[WORD_W-1:0];
			scale_clip = 1'b0;
		end
	end

	assign sub_r = sub_sat(sa, m_q);

	sts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.numer  (dn),
		.denom  (den_q),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot),
		.fault  (div_fault)
	);

	sts_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS), .AW(AW)) u_ratio_ram (
		.clk   (clk),
		.we    (cmd.take_ratio),
		.waddr (addr),
		.wdata (div_quot),
		.re    (cmd.rd_go),
		.raddr (addr),
		.rdata (ratio_rd)
	);

	sts_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS), .AW(AW)) u_srhs_ram (
		.clk   (clk),
		.we    (cmd.take_srhs),
		.waddr (addr),
		.wdata (div_quot),
		.re    (cmd.rd_go),
		.raddr (addr),
		.rdata (srhs_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sing_q      <= 1'b0;
			prev_off_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_solve) begin
				sing_q     <= 1'b0;
				prev_off_q <= '0;
			end else begin
				sing_q <= sing_q | (cmd.scale_go & scale_clip) |
					(cmd.sub_go & sub_r.clip) | (div_done & div_fault);
				if (cmd.save_off) begin
					prev_off_q <= off_q;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (sol_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			diag_q <= row.diag_value;
			off_q  <= row.off_value;
			rhs_q  <= row.rhs_value;
		end
		if (cmd.first_row) begin
			den_q <= row.diag_value;
			num_q <= row.rhs_value;
		end
		if (cmd.mul_go) begin
			prod_q <= mag(ma) * mag(mb);
			mneg_q <= ma[WORD_W-1] ^ mb[WORD_W-1];
		end
		if (cmd.scale_go) begin
			m_q <= scaled;
		end
		if (cmd.sub_go) begin
			case (cmd.sub_sel)
				SS_DEN:  den_q <= sub_r.value;
				SS_NUM:  num_q <= sub_r.value;
				SS_BACK: x_q   <= sub_r.value;
				default: x_q   <= x_q;
			endcase
		end
		if (cmd.take_ratio) begin
			prev_ratio_q <= div_quot;
		end
		if (cmd.take_srhs) begin
			prev_srhs_q <= div_quot;
			x_q         <= div_quot;
			xtop_q      <= div_quot;
		end
		if (cmd.restart) begin
			x_q <= xtop_q;
		end
		if (cmd.out_load) begin
			sol.row_index      <= IDX_W'(addr);
			sol.solution_value <= x_q;
			sol.singular       <= sing_q;
			sol.last_result    <= cmd.out_last;
		end
	end

	assign sol_valid   = out_valid_q;
	assign st.div_done = div_done;
	assign st.div_busy = div_busy;
	assign st.out_busy = out_valid_q;
endmodule

// File: design/sts_ctrl.sv
// Controller: sequences the forward sweep, the check pass and the emission pass.
`timescale 1ns / 1ps
module sts_ctrl import sts_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int AW       = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          row_valid,
	input  logic          row_last,
	output logic          row_ready,
	input  status_t       st,
	output cmd_t          cmd,
	output logic [AW-1:0] addr
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_MUL1  = 5'd1;
	localparam logic [4:0] S_SCL1  = 5'd2;
	localparam logic [4:0] S_SUB1  = 5'd3;
	localparam logic [4:0] S_MUL2  = 5'd4;
	localparam logic [4:0] S_SCL2  = 5'd5;
	localparam logic [4:0] S_SUB2  = 5'd6;
	localparam logic [4:0] S_DIV1  = 5'd7;
	localparam logic [4:0] S_WAIT1 = 5'd8;
	localparam logic [4:0] S_DIV2  = 5'd9;
	localparam logic [4:0] S_WAIT2 = 5'd10;
	localparam logic [4:0] S_CHECK = 5'd11;
	localparam logic [4:0] S_READ  = 5'd12;
	localparam logic [4:0] S_MUL3  = 5'd13;
	localparam logic [4:0] S_SCL3  = 5'd14;
	localparam logic [4:0] S_SUB3  = 5'd15;
	localparam logic [4:0] S_LOAD  = 5'd16;
	localparam logic [4:0] S_EMIT  = 5'd17;
	localparam logic [4:0] S_DONE  = 5'd18;

	logic [4:0]    state_q, state_d;
	logic [AW-1:0] cnt_q, cnt_d, idx_q, idx_d;
	logic          last_q, last_d, pass_q, pass_d;
	logic          last_eff;

	assign last_eff = row_last | (cnt_q == AW'(MAX_ROWS - 1));

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		last_d    = last_q;
		pass_d    = pass_q;
		cmd       = '0;
		addr      = cnt_q;
		row_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				row_ready = 1'b1;
				if (row_valid) begin
					cmd.load_in = 1'b1;
					last_d      = last_eff;
					if (cnt_q == '0) begin
						cmd.first_row = 1'b1;
						state_d       = last_eff ? S_DIV2 : S_DIV1;
					end else begin
						state_d = S_MUL1;
					end
				end
			end
			S_MUL1: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_RATIO;
				state_d     = S_SCL1;
			end
			S_SCL1: begin
				cmd.scale_go = 1'b1;
				state_d      = S_SUB1;
			end
			S_SUB1: begin
				cmd.sub_go  = 1'b1;
				cmd.sub_sel = SS_DEN;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_SRHS;
				state_d     = S_SCL2;
			end
			S_SCL2: begin
				cmd.scale_go = 1'b1;
				state_d      = S_SUB2;
			end
			S_SUB2: begin
				cmd.sub_go  = 1'b1;
				cmd.sub_sel = SS_NUM;
				state_d     = last_q ? S_DIV2 : S_DIV1;
			end
			S_DIV1: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DS_RATIO;
				state_d     = S_WAIT1;
			end
			S_WAIT1: begin
				if (st.div_done) begin
					cmd.take_ratio = 1'b1;
					state_d        = S_DIV2;
				end
			end
			S_DIV2: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DS_SRHS;
				state_d     = S_WAIT2;
			end
			S_WAIT2: begin
				if (st.div_done) begin
					cmd.take_srhs = 1'b1;
					if (!last_q) begin
						cmd.save_off = 1'b1;
						cnt_d        = cnt_q + 1'b1;
						state_d      = S_IDLE;
					end else begin
						idx_d   = cnt_q;
						pass_d  = 1'b0;
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (idx_q == '0) begin
					cmd.restart = 1'b1;
					pass_d      = 1'b1;
					idx_d       = cnt_q;
					state_d     = S_LOAD;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_go = 1'b1;
				addr      = idx_q - 1'b1;
				state_d   = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_BACK;
				state_d     = S_SCL3;
			end
			S_SCL3: begin
				cmd.scale_go = 1'b1;
				state_d      = S_SUB3;
			end
			S_SUB3: begin
				cmd.sub_go  = 1'b1;
				cmd.sub_sel = SS_BACK;
				idx_d       = idx_q - 1'b1;
				state_d     = pass_q ? S_LOAD : S_CHECK;
			end
			S_LOAD: begin
				cmd.out_load = 1'b1;
				cmd.out_last = (idx_q == '0);
				addr         = idx_q;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (!st.out_busy) begin
					state_d = (idx_q == '0) ? S_DONE : S_READ;
				end
			end
			S_DONE: begin
				cmd.clear_solve = 1'b1;
				cnt_d           = '0;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			last_q  <= last_d;
			pass_q  <= pass_d;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !st.out_busy)
		else $error("result loaded over an unsent result");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |-> !st.div_busy)
		else $error("divider started while busy");
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (idx_q != '0 && idx_q <= cnt_q))
		else $error("back substitution read outside stored rows");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT2 && st.div_done && !last_q) |=> (cnt_q != '0))
		else $error("row count not advanced after a stored row");
endmodule

// File: design/symmetric_tridiagonal_solver.sv
// Top level of the streaming symmetric tridiagonal solver.
// A non-final row is multiplied, scaled and subtracted for its denominator and numerator,
// then takes two divisions in the shared divider; a system's first row goes straight to
// the divisions. A final row at index k is divided, then a check pass back-substitutes
// to row 0 before the first result is loaded; later results follow as each one is taken.
// Reset clears the controller, row count, coupling and flags; the stores are not reset.
`timescale 1ns / 1ps
module symmetric_tridiagonal_solver import sts_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic row_valid,
	output logic row_ready,
	input  row_t row,
	output logic sol_valid,
	input  logic sol_ready,
	output sol_t sol
);
	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	cmd_t          cmd;
	status_t       st;
	logic [AW-1:0] addr;

	sts_ctrl #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row_last  (row.last_row),
		.row_ready (row_ready),
		.st        (st),
		.cmd       (cmd),
		.addr      (addr)
	);

	sts_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.row       (row),
		.cmd       (cmd),
		.addr      (addr),
		.st        (st),
		.sol_valid (sol_valid),
		.sol_ready (sol_ready),
		.sol       (sol)
	);
endmodule

// File: bench/tb_checker.sv
// Checker for the tridiagonal solver: predicts each solve from the requests and compares results.
`timescale 1ns / 1ps
module tb_checker import sts_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic row_valid,
	input  logic row_ready,
	input  row_t row,
	input  logic sol_valid,
	input  logic sol_ready,
	input  sol_t sol,
	output int   fail_count,
	output int   pending
);
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	logic signed [31:0] ratio_mem [MAX_ROWS];
	logic signed [31:0] srhs_mem [MAX_ROWS];
	int                 rows_held;
	logic signed [31:0] prev_coupling;
	bit                 fault;
	sol_t               expected_sols [$];

	function automatic logic signed [31:0] clip32(longint v);
		if (v > WMAX) begin
			fault = 1;
			return WMAX[31:0];
		end
		if (v < WMIN) begin
			fault = 1;
			return WMIN[31:0];
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] fx_product(logic signed [31:0] a,
		logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		if (p < 0) begin
			return clip32(-((-p) >>> FRAC_BITS));
		end
		return clip32(p >>> FRAC_BITS);
	endfunction

	function automatic logic signed [31:0] fx_quotient(logic signed [31:0] n,
		logic signed [31:0] d);
		if (d == 0) begin
			fault = 1;
			return 0;
		end
		return clip32((longint'(n) * (64'sd1 <<< FRAC_BITS)) / longint'(d));
	endfunction

	task automatic absorb_row(row_t r);
		int                 k;
		bit                 fin;
		logic signed [31:0] den, num, x;
		sol_t               s;
		k = rows_held;
		fin = r.last_row;
		if (k >= MAX_ROWS - 1) begin
			k = MAX_ROWS - 1;
			fin = 1;
		end
		if (k == 0) begin
			den = r.diag_value;
			num = r.rhs_value;
		end else begin
			den = clip32(longint'(r.diag_value)
				- longint'(fx_product(prev_coupling, ratio_mem[k-1])));
			num = clip32(longint'(r.rhs_value)
				- longint'(fx_product(prev_coupling, srhs_mem[k-1])));
		end
		if (!fin) begin
			ratio_mem[k] = fx_quotient(r.off_value, den);
			srhs_mem[k] = fx_quotient(num, den);
			prev_coupling = r.off_value;
			rows_held = k + 1;
			return;
		end
		srhs_mem[k] = fx_quotient(num, den);
		x = srhs_mem[k];
		begin
			sol_t batch [$];
			s.row_index = k[5:0];
			s.solution_value = x;
			batch.push_back(s);
			for (int i = k - 1; i >= 0; i--) begin
				x = clip32(longint'(srhs_mem[i]) - longint'(fx_product(ratio_mem[i], x)));
				s.row_index = i[5:0];
				s.solution_value = x;
				batch.push_back(s);
			end
			foreach (batch[j]) begin
				batch[j].singular = fault;
				batch[j].last_result = (j == batch.size() - 1);
				expected_sols.push_back(batch[j]);
			end
		end
		rows_held = 0;
		prev_coupling = 0;
		fault = 0;
	endtask

	assign pending = expected_sols.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_held = 0;
			prev_coupling = 0;
			fault = 0;
			fail_count = 0;
		end else begin
			if (row_valid && row_ready) begin
				absorb_row(row);
			end
			if (sol_valid && sol_ready) begin
				if (expected_sols.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result %p", sol);
					end
				end else begin
					sol_t e;
					e = expected_sols.pop_front();
					if (sol !== e) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: expected %p, got %p", e, sol);
						end
					end
				end
			end
		end
	end
endmodule

// File: bench/tb.sv
// Testbench top for the tridiagonal solver: reset, row requests, result stalls and verdict.
`timescale 1ns / 1ps
module tb;
	import sts_pkg::*;

	logic clk;
	logic arst_n;
	logic row_valid;
	logic row_ready;
	row_t row;
	logic sol_valid;
	logic sol_ready;
	sol_t sol;
	int   fail_count;
	int   pending;
	bit   calm;

	symmetric_tridiagonal_solver DUT (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_ready(row_ready), .row(row),
		.sol_valid(sol_valid), .sol_ready(sol_ready), .sol(sol)
	);

	tb_checker CHK (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_ready(row_ready), .row(row),
		.sol_valid(sol_valid), .sol_ready(sol_ready), .sol(sol),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		sol_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (calm || $urandom_range(0, 3) != 0) begin
				sol_ready <= 1;
			end else begin
				sol_ready <= 0;
				repeat ($urandom_range(1, 19) - 1) @(posedge clk);
			end
		end
	end

	function automatic logic signed [31:0] word_pick();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return $urandom;
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	task automatic send_row(logic signed [31:0] d, logic signed [31:0] o,
		logic signed [31:0] r, bit fin);
		if (!calm && $urandom_range(0, 3) == 0) begin
			row_valid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		row_valid <= 1;
		row <= '{diag_value: d, off_value: o, rhs_value: r, last_row: fin};
		do @(posedge clk); while (!row_ready);
	endtask

	task automatic send_system(int n);
		for (int i = 0; i < n; i++) begin
			send_row($signed($urandom_range(32'h0002_0000, 32'h0040_0000))
				* ($urandom_range(0, 1) ? 1 : -1),
				word_pick(), word_pick(), i == n - 1);
		end
	endtask

	initial begin
		int sent;
		arst_n = 0;
		row_valid = 0;
		row = '0;
		calm = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_row(32'sh0001_0000, 0, 32'sh7fffffff, 1);
		send_row(0, 0, 32'sh0001_0000, 1);
		send_row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
		send_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1);
		send_row(32'sh0000_0001, 32'sh0001_0000, 32'sh7fffffff, 1);
		send_row(32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 0);
		send_row(32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 0);
		send_row(32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 1);
		send_row(0, 32'sh0001_0000, 0, 0);
		send_row(32'sh0001_0000, 0, 32'sh0001_0000, 1);
		for (int i = 0; i < 66; i++) begin
			send_row(32'sh0004_0000, 32'sh0001_0000, $urandom, 0);
		end
		send_row(32'sh0004_0000, 0, 32'sh0001_0000, 1);
		sent = 0;
		while (sent < 220) begin
			int n;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 5);
			if (sent > 170) begin
				calm = 1;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_row(word_pick(), word_pick(), word_pick(), $urandom_range(0, 1));
				n = 1;
			end else begin
				send_system(n);
			end
			sent += n;
		end
		send_row(32'sh0001_0000, 0, 0, 1);
		row_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// File: files.f
design/sts_pkg.sv
design/sts_ram.sv
design/sts_div.sv
design/sts_datapath.sv
design/sts_ctrl.sv
design/symmetric_tridiagonal_solver.sv
bench/tb_checker.sv
bench/tb.sv
